// ===== hdl/line_edit_buffer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Line edit buffer assertion macros
// Checks enabled unless NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_EDIT_BUFFER_UNIT_ASSERT_SVH
`define LINE_EDIT_BUFFER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LEB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define LEB_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define LEB_ASSERT(label, clk, rst, prop)
`define LEB_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== hdl/leb_pkg.sv =====
// ----------------------------------------------------------------------------
// Line edit buffer package
// Command codes and sizes shared by the editor modules.
// ----------------------------------------------------------------------------
package leb_pkg;
   localparam int BufBytes = 256;
   localparam int AddrW    = 8;
   localparam int MaxLen   = BufBytes - 2;

   typedef enum logic [3:0] {
      CMD_INSERT = 4'd0, CMD_HOME = 4'd1, CMD_END = 4'd2, CMD_FWD_CHAR = 4'd3,
      CMD_BACK_CHAR = 4'd4, CMD_DEL_BACK_CHAR = 4'd5, CMD_DEL_FWD_CHAR = 4'd6,
      CMD_KILL_START = 4'd7, CMD_KILL_END = 4'd8, CMD_DEL_BACK_WORD = 4'd9,
      CMD_FWD_WORD = 4'd10, CMD_BACK_WORD = 4'd11, CMD_DEL_FWD_WORD = 4'd12,
      CMD_CLEAR = 4'd13, CMD_READ = 4'd14, CMD_NONE = 4'd15
   } cmd_type;

   typedef struct packed {
      logic [AddrW-1:0] cursor;
      logic [AddrW-1:0] length;
      logic             dropped;
      logic [7:0]       data;
   } rsp_type;
endpackage

// ===== hdl/leb_text_ram.sv =====
// ----------------------------------------------------------------------------
// Line edit buffer text RAM
// Single port byte store, registered read.
// ----------------------------------------------------------------------------
module leb_text_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [leb_pkg::AddrW-1:0] addr,
   input  logic [7:0]                wr_data,
   output logic [7:0]                rd_data
);
   import leb_pkg::*;
   logic [7:0] mem [BufBytes];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== hdl/line_edit_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// Line edit buffer unit
// Readline style single line editor over a 256 byte text RAM.
// ----------------------------------------------------------------------------
// Usage: one command transaction enters on req_ (tdata fields below), one
// response transaction leaves on rsp_ per command. The unit works on one
// command at a time; req_tready is high only while idle. Every byte access
// goes through the single RAM port (registered read, one access per cycle),
// so latency follows the bytes touched: moves scan byte by byte, an insert
// shifts each byte right of the cursor and then writes the new bytes, a
// deletion scans and then moves the bytes after the cut left. Worst case is
// a forward word delete over a full line with no breaks (a forward and a
// backward scan of 254 bytes each). The response sits in an output register
// until rsp_tready; while it waits no new command is taken. Reset
// (synchronous, high) empties the line and puts the cursor at 0; RAM contents
// are left unknown and are never read below the length before being written.
// ----------------------------------------------------------------------------
`include "line_edit_buffer_unit_assert.svh"
module line_edit_buffer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] command, [6:4] insert_count, [14:7] insert_byte0,
   // [22:15] insert_byte1, [30:23] insert_byte2, [38:31] insert_byte3,
   // [46:39] read_index, [47] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] cursor_pos, [15:8] line_length, [16] insert_dropped,
   // [24:17] read_data, [31:25] zero
   output logic [31:0] rsp_tdata
);
   import leb_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SEEK_REQ, S_SEEK_WAIT, S_SEEK_TEST,
      S_INS_RD, S_INS_WR, S_INS_NEW, S_CUT_RD, S_CUT_WR, S_DONE, S_RSP
   } state_type;

   // seek phases: char fwd/back, word skip-breaks then skip-word
   typedef enum logic [2:0] {
      P_CHAR_F, P_CHAR_B, P_WF1, P_WF2, P_WB1, P_WB2
   } phase_type;

   state_type        state_ff;
   phase_type        phase_ff;
   cmd_type          cmd_ff;
   logic [AddrW-1:0] cursor_ff, length_ff, pos_ff, lo_ff, hi_ff, idx_ff;
   logic [AddrW-1:0] rd_ff;
   logic [2:0]       cnt_ff, k_ff;
   logic [7:0]       bytes_ff [4];
   logic [7:0]       hold_ff;
   logic             second_ff;  // del fwd word: second seek pending
   rsp_type          rsp_ff;

   logic             ram_we;
   logic [AddrW-1:0] ram_addr;
   logic [7:0]       ram_wd, ram_rd;

   leb_text_ram u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RSP);
   assign rsp_tdata  = {7'd0, rsp_ff.data, rsp_ff.dropped, rsp_ff.length, rsp_ff.cursor};

   // probe address for seeks: the byte that the next step looks at
   logic [AddrW-1:0] probe;
   always_comb begin
      unique case (phase_ff)
         P_CHAR_F, P_WF1, P_WF2: probe = pos_ff + 8'd1;
         P_CHAR_B, P_WB1:        probe = pos_ff - 8'd1;
         default:                probe = pos_ff - 8'd1;
      endcase
   end

   logic [7:0] pb;   // probed byte, 0 at or past the length
   logic       pb_cont, pb_brk;
   assign pb      = (idx_ff < length_ff) ? ram_rd : 8'd0;
   assign pb_cont = (pb[7:6] == 2'b10);
   assign pb_brk  = (pb == 8'h20) || (pb == 8'h2F);

   always_comb begin
      ram_we   = 1'b0;
      ram_addr = idx_ff;
      ram_wd   = hold_ff;
      unique case (state_ff)
         S_SEEK_REQ: ram_addr = probe;
         S_INS_RD:   ram_addr = idx_ff - 8'd1;   // next byte to shift up
         S_CUT_WR:   ram_we   = 1'b1;
         S_INS_NEW: begin
            ram_we = 1'b1;
            ram_wd = bytes_ff[k_ff[1:0]];
         end
         default: ;
      endcase
   end

   // seek finishes: can it step further in the current phase
   logic can_step;
   always_comb begin
      unique case (phase_ff)
         P_CHAR_F, P_WF1, P_WF2: can_step = (pos_ff < length_ff);
         default:                can_step = (pos_ff != 8'd0);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= P_CHAR_F;
         cursor_ff <= '0;
         length_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_tvalid) begin
               cmd_ff      <= cmd_type'(req_tdata[3:0]);
               cnt_ff      <= req_tdata[6:4];
               bytes_ff[0] <= req_tdata[14:7];
               bytes_ff[1] <= req_tdata[22:15];
               bytes_ff[2] <= req_tdata[30:23];
               bytes_ff[3] <= req_tdata[38:31];
               rd_ff       <= req_tdata[46:39];
               rsp_ff      <= '0;
               second_ff   <= 1'b0;
               state_ff    <= S_DECODE;
            end
            S_DECODE: begin
               pos_ff   <= cursor_ff;
               state_ff <= S_DONE;
               unique case (cmd_ff)
                  CMD_INSERT: if (cnt_ff != 3'd0 && cnt_ff <= 3'd4 &&
                                  !(cnt_ff == 3'd1 && bytes_ff[0] < 8'h20)) begin
                     if ({1'b0, length_ff} + {6'd0, cnt_ff} > 9'(MaxLen)) begin
                        rsp_ff.dropped <= 1'b1;
                     end else begin
                        idx_ff   <= length_ff;   // shift from top down
                        state_ff <= S_INS_RD;
                     end
                  end
                  CMD_HOME:  cursor_ff <= '0;
                  CMD_END:   cursor_ff <= length_ff;
                  CMD_FWD_CHAR, CMD_DEL_FWD_CHAR: begin
                     phase_ff <= P_CHAR_F;
                     state_ff <= S_SEEK_REQ;
                  end
                  CMD_BACK_CHAR, CMD_DEL_BACK_CHAR: begin
                     phase_ff <= P_CHAR_B;
                     state_ff <= S_SEEK_REQ;
                  end
                  CMD_FWD_WORD, CMD_DEL_FWD_WORD: begin
                     phase_ff <= P_WF1;
                     state_ff <= S_SEEK_REQ;
                  end
                  CMD_BACK_WORD, CMD_DEL_BACK_WORD: begin
                     phase_ff <= P_WB1;
                     state_ff <= S_SEEK_REQ;
                  end
                  CMD_KILL_START: begin
                     lo_ff <= '0; hi_ff <= cursor_ff; idx_ff <= cursor_ff;
                     state_ff <= S_CUT_RD;
                  end
                  CMD_KILL_END: begin
                     if (length_ff <= cursor_ff) begin
                        lo_ff <= '0; hi_ff <= cursor_ff; idx_ff <= cursor_ff;
                     end else begin
                        lo_ff <= cursor_ff; hi_ff <= length_ff; idx_ff <= length_ff;
                     end
                     state_ff <= S_CUT_RD;
                  end
                  CMD_CLEAR: begin
                     cursor_ff <= '0;
                     length_ff <= '0;
                  end
                  CMD_READ: begin
                     idx_ff   <= rd_ff;
                     state_ff <= S_SEEK_WAIT;
                  end
                  default: ;
               endcase
            end
            S_SEEK_REQ: begin
               if (can_step) begin
                  idx_ff   <= probe;
                  state_ff <= S_SEEK_WAIT;
               end else begin
                  // seek ends where it stands; WF1/WB1 fall into phase two
                  if (phase_ff == P_WF1) phase_ff <= P_WF2;
                  else if (phase_ff == P_WB1) phase_ff <= P_WB2;
                  else state_ff <= S_DONE;
               end
            end
            S_SEEK_WAIT: state_ff <= S_SEEK_TEST;
            S_SEEK_TEST: begin
               if (cmd_ff == CMD_READ) begin
                  rsp_ff.data <= pb;
                  state_ff    <= S_DONE;
               end else if (!can_step && phase_ff != P_WB2 && phase_ff != P_WF2
                            && idx_ff == pos_ff) begin
                  state_ff <= S_DONE;   // not reached, kept safe
               end else begin
                  state_ff <= S_SEEK_REQ;
                  unique case (phase_ff)
                     P_CHAR_F, P_CHAR_B: begin
                        pos_ff <= idx_ff;
                        if (!pb_cont) state_ff <= S_DONE;
                     end
                     P_WF1: begin
                        pos_ff <= idx_ff;
                        if (!pb_brk) phase_ff <= P_WF2;
                     end
                     P_WB1: begin
                        pos_ff <= idx_ff;
                        if (!pb_brk) phase_ff <= P_WB2;
                     end
                     P_WF2: begin
                        // step onto the next byte; a break there ends the word
                        pos_ff <= idx_ff;
                        if (pb_brk) state_ff <= S_DONE;
                     end
                     default: begin  // P_WB2: stop if byte at pos-1 breaks
                        if (pb_brk) state_ff <= S_DONE;
                        else pos_ff <= idx_ff;
                     end
                  endcase
               end
            end
            S_INS_RD: begin
               if (idx_ff == cursor_ff) begin
                  k_ff     <= '0;
                  idx_ff   <= cursor_ff;
                  state_ff <= S_INS_NEW;
               end else begin
                  idx_ff   <= idx_ff - 8'd1;
                  state_ff <= S_INS_WR;
               end
            end
            S_INS_WR: begin
               // data of idx read last cycle lands at idx + cnt (insert)
               // or idx - span (cut)
               hold_ff  <= ram_rd;
               idx_ff   <= (cmd_ff == CMD_INSERT) ? idx_ff + {5'd0, cnt_ff}
                                                  : idx_ff - (hi_ff - lo_ff);
               state_ff <= S_CUT_WR;   // reuse: write then return
               second_ff <= 1'b1;
            end
            S_INS_NEW: begin
               if (k_ff + 3'd1 == cnt_ff) begin
                  cursor_ff <= cursor_ff + {5'd0, cnt_ff};
                  length_ff <= length_ff + {5'd0, cnt_ff};
                  state_ff  <= S_DONE;
               end
               k_ff   <= k_ff + 3'd1;
               idx_ff <= idx_ff + 8'd1;
            end
            S_CUT_RD: begin
               // copy byte at idx down by hi-lo; idx walks hi..length-1
               if (idx_ff >= length_ff) begin
                  if (hi_ff <= cursor_ff) cursor_ff <= cursor_ff - (hi_ff - lo_ff);
                  else if (lo_ff < cursor_ff) cursor_ff <= lo_ff;
                  length_ff <= length_ff - (hi_ff - lo_ff);
                  state_ff  <= S_DONE;
               end else begin
                  state_ff <= S_INS_WR;
               end
            end
            S_CUT_WR: begin
               if (second_ff && cmd_ff == CMD_INSERT) begin
                  idx_ff    <= idx_ff - {5'd0, cnt_ff};
                  second_ff <= 1'b0;
                  state_ff  <= S_INS_RD;
               end else begin
                  idx_ff    <= idx_ff + (hi_ff - lo_ff) + 8'd1;
                  second_ff <= 1'b0;
                  state_ff  <= S_CUT_RD;
               end
            end
            S_DONE: begin
               if (cmd_ff == CMD_DEL_FWD_WORD && phase_ff == P_WF2) begin
                  // forward seek done: word end in pos, now seek back from it
                  hi_ff <= pos_ff; phase_ff <= P_WB1; second_ff <= 1'b1;
                  state_ff <= S_SEEK_REQ;
               end else if ((cmd_ff == CMD_DEL_BACK_CHAR || cmd_ff == CMD_DEL_BACK_WORD)
                            && pos_ff != cursor_ff) begin
                  lo_ff <= pos_ff; hi_ff <= cursor_ff; idx_ff <= cursor_ff;
                  state_ff <= S_CUT_RD;
               end else if (cmd_ff == CMD_DEL_FWD_CHAR && pos_ff != cursor_ff) begin
                  lo_ff <= cursor_ff; hi_ff <= pos_ff; idx_ff <= pos_ff;
                  pos_ff <= cursor_ff; state_ff <= S_CUT_RD;
               end else if (cmd_ff == CMD_DEL_FWD_WORD && second_ff && pos_ff != hi_ff) begin
                  lo_ff <= pos_ff; idx_ff <= hi_ff; pos_ff <= hi_ff;
                  second_ff <= 1'b0; state_ff <= S_CUT_RD;
               end else begin
                  if (cmd_ff == CMD_FWD_CHAR || cmd_ff == CMD_BACK_CHAR ||
                      cmd_ff == CMD_FWD_WORD || cmd_ff == CMD_BACK_WORD) begin
                     cursor_ff     <= pos_ff;
                     rsp_ff.cursor <= pos_ff;
                  end else begin
                     rsp_ff.cursor <= cursor_ff;
                  end
                  rsp_ff.length <= length_ff;
                  state_ff      <= S_RSP;
               end
            end
            S_RSP: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `LEB_ASSERT(a_len_max, clock, reset, (length_ff <= 8'(MaxLen)))
   `LEB_ASSERT(a_cur_len, clock, reset, (state_ff == S_IDLE) |-> (cursor_ff <= length_ff))
   `LEB_ASSERT(a_ready_excl, clock, reset, !(req_tready && rsp_tvalid))
   `LEB_ASSERT(a_rsp_hold, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
endmodule
